[design/tlg_pkg.sv]
// Shared types and constants for the toroidal life generation block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package tlg_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [3:0] LIFE_BIRTH = 4'd3;
  localparam logic [3:0] LIFE_KEEP  = 4'd2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;
  localparam int ROW_IDX_W  = 4;
  localparam int CELLS_W    = 64;
  localparam int ROW_CMD_W  = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP
  } tlg_state_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 rd_host;
    logic [ROW_CMD_W-1:0] rd_row;
    logic                 wr_en;
    logic                 wr_host;
    logic [ROW_CMD_W-1:0] wr_row;
    logic                 shift;
    logic                 flip;
    logic                 out_load;
  } tlg_cmd_t;

  typedef struct packed {
    logic row_ok;
  } tlg_stat_t;

endpackage

`default_nettype wire

[design/tlg_ctrl.sv]
// Controller state machine: request handshake, generation sweep sequencing.
// Depends on tlg_pkg; drives tlg_datapath through tlg_cmd_t.
`default_nettype none

module tlg_ctrl #(
  parameter int ROWS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [1:0]       in_cmd,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire tlg_pkg::tlg_stat_t stat,
  output tlg_pkg::tlg_cmd_t     cmd
);
  import tlg_pkg::*;

  localparam int IW = $clog2(ROWS + 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(ROWS + 1);
  localparam logic [IW-1:0] FIRST_WR = IW'(2);

  tlg_state_t    state_r, state_nxt;
  logic [IW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          d1_v_r, d1_v_nxt;
  logic [IW-1:0] d1_idx_r, d1_idx_nxt;
  logic          d2_v_r, d2_v_nxt;
  logic [IW-1:0] d2_idx_r, d2_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      d1_v_r      <= 1'b0;
      d1_idx_r    <= '0;
      d2_v_r      <= 1'b0;
      d2_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      d1_v_r      <= d1_v_nxt;
      d1_idx_r    <= d1_idx_nxt;
      d2_v_r      <= d2_v_nxt;
      d2_idx_r    <= d2_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    d1_v_nxt      = 1'b0;
    d1_idx_nxt    = rd_cnt_r;
    d2_v_nxt      = 1'b0;
    d2_idx_nxt    = d1_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_cmd)
            CMD_WRITE: begin
              cmd.wr_en   = stat.row_ok;
              cmd.wr_host = 1'b1;
            end
            CMD_STEP: begin
              rd_cnt_nxt = '0;
              state_nxt  = ST_STEP;
            end
            CMD_READ: begin
              cmd.rd_en   = 1'b1;
              cmd.rd_host = 1'b1;
              state_nxt   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_STEP: begin
        if (rd_cnt_r <= LAST_IDX) begin
          cmd.rd_en  = 1'b1;
          rd_cnt_nxt = IW'(rd_cnt_r + 1'b1);
          d1_v_nxt   = 1'b1;
          if (rd_cnt_r == '0) begin
            cmd.rd_row = ROW_CMD_W'(ROWS - 1);
          end else if (rd_cnt_r == LAST_IDX) begin
            cmd.rd_row = '0;
          end else begin
            cmd.rd_row = ROW_CMD_W'(IW'(rd_cnt_r - 1'b1));
          end
        end
        cmd.shift = d1_v_r;
        d2_v_nxt  = d1_v_r && (d1_idx_r >= FIRST_WR);
        cmd.wr_en  = d2_v_r;
        cmd.wr_row = ROW_CMD_W'(IW'(d2_idx_r - FIRST_WR));
        if (d2_v_r && d2_idx_r == LAST_IDX) begin
          cmd.flip  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[design/tlg_datapath.sv]
// Datapath: two-bank grid memory, row valid bits, three-row window, life rule.
// Depends on tlg_pkg; commanded by tlg_ctrl.
`default_nettype none

module tlg_datapath #(
  parameter int ROWS = 16,
  parameter int COLS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [tlg_pkg::ROW_IDX_W-1:0] in_row_index,
  input  wire logic [tlg_pkg::CELLS_W-1:0]   in_row_cells,
  input  wire tlg_pkg::tlg_cmd_t             cmd,
  output tlg_pkg::tlg_stat_t                 stat,
  output logic [tlg_pkg::CELLS_W-1:0]        out_row_value
);
  import tlg_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 ** AW;

  logic [COLS-1:0]      mem_r [0:DEPTH-1];
  logic [1:0][ROWS-1:0] vld_r;
  logic                 live_r;
  logic [COLS-1:0]      rdq_r;
  logic                 rdv_r;
  logic [COLS-1:0]      up_r, mid_r, dn_r;
  logic [COLS-1:0]      out_r;

  logic [ROW_CMD_W:0] rowx;
  logic [RW-1:0]      host_row;
  logic [RW-1:0]      rd_row;
  logic [RW-1:0]      wr_row;
  logic               wr_bank;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [COLS-1:0]    wr_data;
  logic [COLS-1:0]    rd_data;
  logic [COLS-1:0]    life_row;

  assign rowx        = (ROW_CMD_W + 1)'(in_row_index);
  assign stat.row_ok = rowx < (ROW_CMD_W + 1)'(ROWS);
  assign host_row    = rowx[RW-1:0];

  assign rd_row  = cmd.rd_host ? host_row : cmd.rd_row[RW-1:0];
  assign rd_addr = {live_r, rd_row};
  assign wr_row  = cmd.wr_host ? host_row : cmd.wr_row[RW-1:0];
  assign wr_bank = cmd.wr_host ? live_r : !live_r;
  assign wr_addr = {wr_bank, wr_row};
  assign wr_data = cmd.wr_host ? in_row_cells[COLS-1:0] : life_row;
  assign rd_data = rdq_r & {COLS{rdv_r}};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdq_r <= mem_r[rd_addr];
      rdv_r <= vld_r[live_r][rd_row] && (stat.row_ok || !cmd.rd_host);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      live_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        vld_r[wr_bank][wr_row] <= 1'b1;
      end
      if (cmd.flip) begin
        live_r <= !live_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      up_r  <= mid_r;
      mid_r <= dn_r;
      dn_r  <= rd_data;
    end
    if (cmd.out_load) begin
      out_r <= rd_data;
    end
  end

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    localparam int LF = (c == 0) ? COLS - 1 : c - 1;
    localparam int RT = (c == COLS - 1) ? 0 : c + 1;
    logic [3:0] n;
    assign n = 4'(up_r[LF]) + 4'(up_r[c]) + 4'(up_r[RT])
             + 4'(mid_r[LF]) + 4'(mid_r[RT])
             + 4'(dn_r[LF]) + 4'(dn_r[c]) + 4'(dn_r[RT]);
    assign life_row[c] = (n == LIFE_BIRTH) || (mid_r[c] && n == LIFE_KEEP);
  end

  assign out_row_value = CELLS_W'(out_r);

endmodule

`default_nettype wire

[design/toroidal_life_generation_top.sv]
// Toroidal life generation block: stream ports, controller and datapath.
// Depends on tlg_pkg, tlg_ctrl and tlg_datapath.
// Write request: written on accept. Read request: memory output register, then result
// register. Step request: no accept until the sweep ends; one memory read port feeds
// ROWS + 2 row reads into a three-row window, one row word per cycle.
// Synchronous active-low reset: grid reads all dead, no result pending.
`default_nettype none

module toroidal_life_generation_top #(
  parameter int ROWS = 16,
  parameter int COLS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [1:0] cmd, [5:2] row_index, [69:6] row_cells, [71:70] zero
  input  wire logic [tlg_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [63:0] row_value
  output logic [tlg_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import tlg_pkg::*;

  tlg_cmd_t  cmd;
  tlg_stat_t stat;

  tlg_ctrl #(
    .ROWS(ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tdata[1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tlg_datapath #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_row_index  (in_tdata[5:2]),
    .in_row_cells  (in_tdata[69:6]),
    .cmd           (cmd),
    .stat          (stat),
    .out_row_value (out_tdata)
  );

endmodule

`default_nettype wire

[design/tlg_checker.sv]
// Port-level checker for the toroidal life generation top level, with bind.
// Depends on tlg_pkg and toroidal_life_generation_top.
`default_nettype none

module tlg_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [tlg_pkg::IN_DATA_W-1:0] in_tdata,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [tlg_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tlg_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tdata[1:0] == CMD_READ |=> ##1 out_tvalid)
    else $error("read request gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_acc && in_tdata[1:0] == CMD_READ, 2))
    else $error("result without a read request");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tdata[1:0] == CMD_STEP |=> !in_tready)
    else $error("request taken during a generation sweep");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind toroidal_life_generation_top tlg_checker u_tlg_checker (.*);

`default_nettype wire
